// ===== hdl/quintic_segment_interpolator_core_defines.svh =====
// ---------------------------------------------------------------------------
// quintic segment interpolator assertion macros
// shared property shorthands for the interpolator core
// ---------------------------------------------------------------------------
`ifndef QUINTIC_SEGMENT_INTERPOLATOR_CORE_DEFINES_SVH
`define QUINTIC_SEGMENT_INTERPOLATOR_CORE_DEFINES_SVH

// same-cycle implication
`define QSI_ASSERT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("qsi assertion failed");

// next-cycle implication
`define QSI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("qsi next-cycle assertion failed");

`endif

// ===== hdl/qsi_pkg.sv =====
// ---------------------------------------------------------------------------
// qsi_pkg
// widths and divider handshake types of the quintic segment interpolator
// ---------------------------------------------------------------------------
package qsi_pkg;

  localparam int QSI_JOINTS = 6;
  localparam int QSI_NCOEF  = 6;
  localparam int QSI_BW     = 256;
  localparam int QSI_QW     = 64;
  localparam int QSI_DW     = QSI_BW - QSI_QW;

  typedef struct packed {
    logic              start;
    logic [QSI_BW-1:0] num;
    logic [QSI_DW-1:0] den;
  } qsi_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              ovf;
    logic [QSI_QW-1:0] quot;
  } qsi_div_rsp_t;

endpackage

// ===== hdl/quintic_segment_interpolator_core.sv =====
// ---------------------------------------------------------------------------
// quintic_segment_interpolator_core
// per-joint quintic segment bank: solves coefficients on load, evaluates
// position, velocity and acceleration of every joint on query
// ---------------------------------------------------------------------------
// One transaction at a time is worked on. In a load, each of the three upper
// coefficients needs a numerator and a denominator built by the 32x32 limb
// multiplier and a run of the bit-serial divider. A query evaluates each
// joint by Horner evaluation through the same limb multiplier with one
// coefficient memory read per step, and gives one result per joint in joint
// order.
// Coefficients live in a synchronous memory of JOINTS*6 words and segment
// times in a second one of JOINTS words; a joint never loaded reads as zero.
`include "quintic_segment_interpolator_core_defines.svh"

module quintic_segment_interpolator_core import qsi_pkg::*; #(
  parameter int JOINTS = QSI_JOINTS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // joint, seg_start, seg_end, start_pos, start_vel, start_acc, end_pos,
  // end_vel, end_acc, query_time
  input  logic [295:0] in_tdata,
  // kind
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // joint_out, position, velocity, acceleration
  output logic [103:0] out_tdata,
  // status
  output logic [0:0]   out_tuser,
  output logic         out_tlast
);

  localparam int JW   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int CFD  = JOINTS * QSI_NCOEF;
  localparam int CFAW = $clog2(CFD);
  localparam int TW   = 40;
  localparam int TMW  = 70;
  localparam int BW   = QSI_BW;
  localparam logic [JW-1:0] JMAX = JW'(JOINTS - 1);

  localparam logic KIND_LOAD     = 1'b0;
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic signed [TW-1:0] K20  = TW'(20);
  localparam logic signed [TW-1:0] KM30 = -TW'(30);
  localparam logic signed [TW-1:0] K12  = TW'(12);
  localparam logic signed [TW-1:0] K8   = TW'(8);
  localparam logic signed [TW-1:0] K14  = TW'(14);
  localparam logic signed [TW-1:0] K16  = TW'(16);
  localparam logic signed [TW-1:0] K6   = TW'(6);
  localparam logic signed [TW-1:0] K3   = TW'(3);
  localparam logic signed [TW-1:0] K2   = TW'(2);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_LP, S_LV, S_LA, S_LABS, S_LDIV, S_LDWT, S_LWLO, S_LOUT,
    S_ETRD, S_ETAU, S_ERD, S_ECF, S_EADD, S_ERND, S_ESAT, S_EOUT
  } state_t;

  state_t          state_r;
  state_t          ret_r;
  logic            kind_r;
  logic [2:0]      joint_r;
  logic [31:0]     s_r, e_r, q_r;
  logic [31:0]     p0_r, v0_r, a0_r, p1_r, v1_r, a1_r;
  logic            status_r;
  logic [BW-1:0]   x_r, y_r;
  logic [31:0]     carry_r, m_r;
  logic [2:0]      lcnt_r, rep_r, k_r;
  logic [1:0]      c_r, r_r;
  logic [JW-1:0]   jcnt_r;
  logic signed [TMW-1:0] term_r;
  logic            neg_r;
  logic [31:0]     pos_r, vel_r, acc_r;
  logic [JOINTS-1:0] vld_r;
  logic            out_tvalid_r;
  logic [103:0]    out_tdata_r;
  logic            out_tlast_r;
  logic [0:0]      out_tuser_r;

  logic [63:0]     cf_mem [CFD];
  logic [63:0]     tm_mem [JOINTS];
  logic [63:0]     cf_rd_r, tm_rd_r;

  logic            cf_we, tm_we;
  logic [CFAW-1:0] cf_waddr, cf_raddr;
  logic [63:0]     cf_wdata;
  logic [JW-1:0]   jl;

  qsi_div_req_t    div_req;
  qsi_div_rsp_t    div_rsp;

  logic            out_free;
  logic            out_load;
  logic            last_go;
  logic            accept;
  logic            reject;
  logic [31:0]     tq;
  logic signed [TW-1:0] h_w, v0_w, v1_w, a0_w, a1_w;
  logic signed [TW-1:0] pterm, vterm, aterm;
  logic [63:0]     prod_w;
  logic [BW-1:0]   abs_w, absh_w, addend_w, rnd_w, sxterm_w;
  logic signed [BW-1:0] shf_w;
  logic [31:0]     sat_w;
  logic [63:0]     coef_w;
  logic [63:0]     cf_val;
  logic [31:0]     ts_w, te_w, tau_w;
  logic [4:0]      dmul_w;

  function automatic logic [CFAW-1:0] cf_addr(input logic [JW-1:0] j,
                                               input logic [2:0] k);
    return CFAW'(j) * CFAW'(QSI_NCOEF) + CFAW'(k);
  endfunction

  function automatic logic [BW-1:0] sx_t(input logic signed [TW-1:0] v);
    return {{(BW-TW){v[TW-1]}}, v};
  endfunction

  assign out_free = !out_tvalid_r || out_tready;
  assign out_load = ((state_r == S_LOUT) || (state_r == S_EOUT)) && out_free;
  assign last_go  = (state_r == S_EOUT) && out_free && (jcnt_r == JMAX);
  assign in_tready = (state_r == S_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign reject   = (in_tdata[66:35] <= in_tdata[34:3]) ||
                    ({29'd0, in_tdata[2:0]} >= 32'(JOINTS));
  assign tq       = e_r - s_r;
  assign jl       = JW'(joint_r);

  // numerator terms
  assign h_w  = {{(TW-32){p1_r[31]}}, p1_r} - {{(TW-32){p0_r[31]}}, p0_r};
  assign v0_w = {{(TW-32){v0_r[31]}}, v0_r};
  assign v1_w = {{(TW-32){v1_r[31]}}, v1_r};
  assign a0_w = {{(TW-32){a0_r[31]}}, a0_r};
  assign a1_w = {{(TW-32){a1_r[31]}}, a1_r};

  always_comb begin
    case (c_r)
      2'd0: begin
        pterm = K20 * h_w;
        vterm = -(K8 * v1_w + K12 * v0_w);
        aterm = a1_w - K3 * a0_w;
      end
      2'd1: begin
        pterm = KM30 * h_w;
        vterm = K14 * v1_w + K16 * v0_w;
        aterm = K3 * a0_w - K2 * a1_w;
      end
      default: begin
        pterm = K12 * h_w;
        vterm = -(K6 * (v1_w + v0_w));
        aterm = a1_w - a0_w;
      end
    endcase
  end

  // limb multiplier
  assign prod_w = {32'd0, x_r[31:0]} * {32'd0, m_r} + {32'd0, carry_r};

  // magnitude and pre-shift of the numerator
  assign abs_w = y_r[BW-1] ? (~y_r + BW'(1)) : y_r;
  always_comb begin
    case (c_r)
      2'd0:    absh_w = abs_w << 40;
      2'd1:    absh_w = abs_w << 64;
      default: absh_w = abs_w << 88;
    endcase
  end

  // coefficient saturation
  always_comb begin
    if (!neg_r) begin
      coef_w = (div_rsp.ovf || div_rsp.quot[63]) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                 : div_rsp.quot;
    end else begin
      coef_w = (div_rsp.ovf || div_rsp.quot > 64'h8000_0000_0000_0000)
               ? 64'h8000_0000_0000_0000 : (64'd0 - div_rsp.quot);
    end
  end

  // evaluation datapath
  assign cf_val = vld_r[jcnt_r] ? cf_rd_r : 64'd0;
  assign ts_w   = vld_r[jcnt_r] ? tm_rd_r[31:0] : 32'd0;
  assign te_w   = vld_r[jcnt_r] ? tm_rd_r[63:32] : 32'd0;
  assign tau_w  = (q_r <= ts_w) ? 32'd0 : ((q_r >= te_w) ? (te_w - ts_w) : (q_r - ts_w));

  always_comb begin
    case (r_r)
      2'd0: dmul_w = 5'd1;
      2'd1: dmul_w = {2'b00, k_r};
      default: begin
        case (k_r)
          3'd2:    dmul_w = 5'd2;
          3'd3:    dmul_w = 5'd6;
          3'd4:    dmul_w = 5'd12;
          3'd5:    dmul_w = 5'd20;
          default: dmul_w = 5'd0;
        endcase
      end
    endcase
  end

  assign sxterm_w = {{(BW-TMW){term_r[TMW-1]}}, term_r};
  always_comb begin
    case (k_r)
      3'd4:    addend_w = sxterm_w << 24;
      3'd3:    addend_w = sxterm_w << 48;
      3'd2:    addend_w = sxterm_w << 72;
      3'd1:    addend_w = sxterm_w << 96;
      3'd0:    addend_w = sxterm_w << 120;
      default: addend_w = sxterm_w;
    endcase
  end

  always_comb begin
    case (r_r)
      2'd0: begin
        rnd_w = BW'(1) << 135;
        shf_w = $signed(x_r) >>> 136;
      end
      2'd1: begin
        rnd_w = BW'(1) << 111;
        shf_w = $signed(x_r) >>> 112;
      end
      default: begin
        rnd_w = BW'(1) << 87;
        shf_w = $signed(x_r) >>> 88;
      end
    endcase
  end

  assign sat_w = ((&shf_w[BW-1:31]) || !(|shf_w[BW-1:31])) ? shf_w[31:0]
               : (shf_w[BW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  // memory ports
  assign cf_raddr = cf_addr(jcnt_r, k_r);
  assign cf_we    = (state_r == S_LDWT && div_rsp.done) || (state_r == S_LWLO);
  assign tm_we    = (state_r == S_LWLO) && (k_r == 3'd2);
  assign cf_waddr = (state_r == S_LDWT) ? cf_addr(jl, {1'b0, c_r} + 3'd3)
                                        : cf_addr(jl, k_r);
  always_comb begin
    if (state_r == S_LDWT) begin
      cf_wdata = coef_w;
    end else begin
      case (k_r)
        3'd0:    cf_wdata = {{16{p0_r[31]}}, p0_r, 16'd0};
        3'd1:    cf_wdata = {{16{v0_r[31]}}, v0_r, 16'd0};
        default: cf_wdata = {{17{a0_r[31]}}, a0_r, 15'd0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cf_we) begin
      cf_mem[cf_waddr] <= cf_wdata;
    end
    cf_rd_r <= cf_mem[cf_raddr];
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      tm_mem[jl] <= {e_r, s_r};
    end
    tm_rd_r <= tm_mem[jcnt_r];
  end

  assign div_req.start = (state_r == S_LDIV);
  assign div_req.num   = y_r;
  assign div_req.den   = x_r[QSI_DW-1:0];

  qsi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      vld_r        <= '0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r  <= in_tuser[0];
            joint_r <= in_tdata[2:0];
            s_r     <= in_tdata[34:3];
            e_r     <= in_tdata[66:35];
            p0_r    <= in_tdata[98:67];
            v0_r    <= in_tdata[130:99];
            a0_r    <= in_tdata[162:131];
            p1_r    <= in_tdata[194:163];
            v1_r    <= in_tdata[226:195];
            a1_r    <= in_tdata[258:227];
            q_r     <= in_tdata[290:259];
            c_r     <= 2'd0;
            jcnt_r  <= '0;
            if (in_tuser[0] == KIND_LOAD) begin
              status_r <= reject ? STATUS_REJECT : STATUS_OK;
              state_r  <= reject ? S_LOUT : S_LP;
            end else begin
              state_r <= S_ETRD;
            end
          end
        end
        S_MUL: begin
          x_r     <= {prod_w[31:0], x_r[BW-1:32]};
          carry_r <= (lcnt_r == 3'd7) ? 32'd0 : prod_w[63:32];
          lcnt_r  <= lcnt_r + 3'd1;
          if (lcnt_r == 3'd7) begin
            rep_r   <= rep_r - 3'd1;
            if (rep_r == 3'd1) begin
              state_r <= ret_r;
            end
          end
        end
        S_LP: begin
          y_r     <= sx_t(pterm) << 48;
          x_r     <= sx_t(vterm);
          m_r     <= tq;
          carry_r <= 32'd0;
          lcnt_r  <= 3'd0;
          rep_r   <= 3'd1;
          ret_r   <= S_LV;
          state_r <= S_MUL;
        end
        S_LV: begin
          y_r     <= y_r + (x_r << 24);
          x_r     <= sx_t(aterm);
          rep_r   <= 3'd2;
          ret_r   <= S_LA;
          state_r <= S_MUL;
        end
        S_LA: begin
          y_r     <= y_r + x_r;
          state_r <= S_LABS;
        end
        S_LABS: begin
          neg_r   <= y_r[BW-1];
          y_r     <= absh_w;
          x_r     <= BW'(2);
          rep_r   <= {1'b0, c_r} + 3'd3;
          ret_r   <= S_LDIV;
          state_r <= S_MUL;
        end
        S_LDIV: begin
          state_r <= S_LDWT;
        end
        S_LDWT: begin
          if (div_rsp.done) begin
            if (c_r == 2'd2) begin
              k_r     <= 3'd0;
              state_r <= S_LWLO;
            end else begin
              c_r     <= c_r + 2'd1;
              state_r <= S_LP;
            end
          end
        end
        S_LWLO: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd2) begin
            vld_r[jl] <= 1'b1;
            state_r   <= S_LOUT;
          end
        end
        S_LOUT: begin
          if (out_free) begin
            out_tdata_r  <= {5'd0, 96'd0, joint_r};
            out_tuser_r  <= status_r;
            out_tlast_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_ETRD: begin
          state_r <= S_ETAU;
        end
        S_ETAU: begin
          m_r     <= tau_w;
          r_r     <= 2'd0;
          k_r     <= 3'd5;
          x_r     <= '0;
          state_r <= S_ERD;
        end
        S_ERD: begin
          state_r <= S_ECF;
        end
        S_ECF: begin
          term_r  <= $signed(cf_val) * $signed({1'b0, dmul_w});
          carry_r <= 32'd0;
          lcnt_r  <= 3'd0;
          rep_r   <= 3'd1;
          ret_r   <= S_EADD;
          state_r <= (k_r == 3'd5) ? S_EADD : S_MUL;
        end
        S_EADD: begin
          x_r <= x_r + addend_w;
          if (k_r == {1'b0, r_r}) begin
            state_r <= S_ERND;
          end else begin
            k_r     <= k_r - 3'd1;
            state_r <= S_ERD;
          end
        end
        S_ERND: begin
          x_r     <= x_r + rnd_w;
          state_r <= S_ESAT;
        end
        S_ESAT: begin
          case (r_r)
            2'd0:    pos_r <= sat_w;
            2'd1:    vel_r <= sat_w;
            default: acc_r <= sat_w;
          endcase
          if (r_r == 2'd2) begin
            state_r <= S_EOUT;
          end else begin
            r_r     <= r_r + 2'd1;
            k_r     <= 3'd5;
            x_r     <= '0;
            state_r <= S_ERD;
          end
        end
        S_EOUT: begin
          if (out_free) begin
            out_tdata_r  <= {5'd0, acc_r, vel_r, pos_r, 3'(jcnt_r)};
            out_tuser_r  <= STATUS_OK;
            out_tlast_r  <= (jcnt_r == JMAX);
            if (jcnt_r == JMAX) begin
              state_r <= S_IDLE;
            end else begin
              jcnt_r  <= jcnt_r + JW'(1);
              state_r <= S_ETRD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `QSI_ASSERT(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy)
  `QSI_ASSERT(a_cf_write_on_load, clk, rst_n, cf_we, kind_r == KIND_LOAD)
  `QSI_ASSERT(a_idle_div_quiet, clk, rst_n, state_r == S_IDLE, !div_rsp.busy)
  `QSI_ASSERT_NEXT(a_last_joint_ends, clk, rst_n, last_go, state_r == S_IDLE)

endmodule

// ===== hdl/qsi_div.sv =====
// ---------------------------------------------------------------------------
// qsi_div
// restoring divider, one quotient bit per cycle, 64-bit quotient with
// overflow flag when the quotient does not fit
// ---------------------------------------------------------------------------
module qsi_div import qsi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  qsi_div_req_t req,
  output qsi_div_rsp_t rsp
);

  localparam int CW = $clog2(QSI_QW);

  logic              busy_r;
  logic              done_r;
  logic              ovf_r;
  logic [QSI_DW-1:0] rem_r;
  logic [QSI_DW-1:0] den_r;
  logic [QSI_QW-1:0] lo_r;
  logic [CW-1:0]     cnt_r;

  logic [QSI_DW:0]   trial;
  logic [QSI_DW:0]   diff;
  logic              ge;
  logic [QSI_DW-1:0] hi;

  assign hi    = req.num[QSI_BW-1:QSI_QW];
  assign trial = {rem_r, lo_r[QSI_QW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        den_r <= req.den;
        lo_r  <= req.num[QSI_QW-1:0];
        rem_r <= hi;
        cnt_r <= '0;
        if (hi >= req.den) begin
          ovf_r  <= 1'b1;
          done_r <= 1'b1;
        end else begin
          ovf_r  <= 1'b0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[QSI_DW-1:0] : trial[QSI_DW-1:0];
        lo_r  <= {lo_r[QSI_QW-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(QSI_QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.quot = lo_r;

endmodule

// ===== tb/tb_quintic_segment_interpolator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_quintic_segment_interpolator_core
// Drives segment loads and all-joint queries into the interpolator core.
// Each result is checked against an exact wide-integer quintic solver and
// evaluator kept alongside, with random idling on both stream sides.
// ---------------------------------------------------------------------------
module tb_quintic_segment_interpolator_core;
  import qsi_pkg::*;

  localparam int NJ = QSI_JOINTS;
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_REJECT  = 1'b1;

  typedef struct {
    logic        kind;
    logic [2:0]  joint;
    logic [31:0] seg_start, seg_end;
    logic [31:0] p0, v0, a0, p1, v1, a1;
    logic [31:0] qtime;
  } seg_item_t;

  typedef struct {
    logic [2:0]  joint;
    logic [31:0] pos, vel, acc;
    logic        status;
    logic        last;
  } kin_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [295:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         out_tlast;

  logic [63:0] coef_bank [NJ*6];
  logic [31:0] seg_t0 [NJ];
  logic [31:0] seg_t1 [NJ];
  kin_result_t pending_kin [$];
  int          mismatches = 0;
  bit          calm = 0;

  quintic_segment_interpolator_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("quintic_segment_interpolator_core verification failed");
    $finish;
  end

  function automatic logic [63:0] solve_coef(logic signed [63:0] pt, logic signed [63:0] vt,
                                             logic signed [63:0] at, logic [31:0] tq, int pw);
    logic signed [319:0] n, ps, vs, as_, tqs;
    logic [319:0] mag, den, q;
    logic neg;
    ps = pt; vs = vt; as_ = at;
    tqs = {288'd0, tq};
    n = (ps <<< 48) + ((vs * tqs) <<< 24) + as_ * tqs * tqs;
    neg = n[319];
    mag = neg ? -n : n;
    mag = mag << (24 * pw - 32);
    den = 320'd2;
    for (int i = 0; i < pw; i++) den = den * {288'd0, tq};
    q = mag / den;
    if (!neg) return (q[319:63] != 0) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
    if (q[319:64] != 0 || q[63:0] > 64'h8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
    return -q[63:0];
  endfunction

  function automatic logic [31:0] eval_deriv(int jn, logic [31:0] tau, int r);
    logic signed [319:0] sum, t, ts, cs;
    int maxj, sh, m;
    maxj = 5 - r;
    sh = 16 + 24 * maxj;
    sum = '0;
    ts = {288'd0, tau};
    for (int k = r; k <= 5; k++) begin
      m = 1;
      for (int i = 0; i < r; i++) m = m * (k - i);
      cs = $signed(coef_bank[jn*6+k]);
      t = cs * m;
      for (int j = 0; j < k - r; j++) t = t * ts;
      t = t <<< (24 * (maxj - (k - r)));
      sum = sum + t;
    end
    t = 320'sd1;
    sum = (sum + (t <<< (sh - 1))) >>> sh;
    if (sum > 320'sd2147483647) return 32'h7FFF_FFFF;
    if (sum < -320'sd2147483648) return 32'h8000_0000;
    return sum[31:0];
  endfunction

  // appends one expected result at the tail of the expected queue
  function automatic void queue_expected(kin_result_t r);
    pending_kin.insert(pending_kin.size(), r);
  endfunction

  // updates the segment bank and queues the expected results of one transaction
  task automatic predict_kinematics(seg_item_t it);
    kin_result_t r;
    logic signed [63:0] p0, v0, a0, p1, v1, a1, h;
    logic [31:0] tq, tau;
    if (it.kind == KIND_LOAD) begin
      r = '{joint: it.joint, pos: '0, vel: '0, acc: '0, status: ST_OK, last: 1'b1};
      if (it.seg_end <= it.seg_start || it.joint >= NJ) begin
        r.status = ST_REJECT;
      end else begin
        p0 = $signed(it.p0); v0 = $signed(it.v0); a0 = $signed(it.a0);
        p1 = $signed(it.p1); v1 = $signed(it.v1); a1 = $signed(it.a1);
        h = p1 - p0;
        tq = it.seg_end - it.seg_start;
        coef_bank[it.joint*6+0] = p0 <<< 16;
        coef_bank[it.joint*6+1] = v0 <<< 16;
        coef_bank[it.joint*6+2] = a0 <<< 15;
        coef_bank[it.joint*6+3] = solve_coef(20*h, -(8*v1 + 12*v0), a1 - 3*a0, tq, 3);
        coef_bank[it.joint*6+4] = solve_coef(-30*h, 14*v1 + 16*v0, 3*a0 - 2*a1, tq, 4);
        coef_bank[it.joint*6+5] = solve_coef(12*h, -6*(v1 + v0), a1 - a0, tq, 5);
        seg_t0[it.joint] = it.seg_start;
        seg_t1[it.joint] = it.seg_end;
      end
      queue_expected(r);
    end else begin
      for (int j = 0; j < NJ; j++) begin
        if (it.qtime <= seg_t0[j]) tau = '0;
        else if (it.qtime >= seg_t1[j]) tau = seg_t1[j] - seg_t0[j];
        else tau = it.qtime - seg_t0[j];
        r.joint = 3'(j);
        r.pos = eval_deriv(j, tau, 0);
        r.vel = eval_deriv(j, tau, 1);
        r.acc = eval_deriv(j, tau, 2);
        r.status = ST_OK;
        r.last = (j == NJ - 1);
        queue_expected(r);
      end
    end
  endtask

  task automatic send_item(seg_item_t it);
    if (!calm && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {5'd0, it.qtime, it.a1, it.v1, it.p1, it.a0, it.v0, it.p0,
                  it.seg_end, it.seg_start, it.joint};
    do @(posedge clk); while (!in_tready);
    predict_kinematics(it);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    kin_result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_kin.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          e = pending_kin[0];
          pending_kin.delete(0);
          if (out_tdata[2:0] !== e.joint || out_tdata[34:3] !== e.pos ||
              out_tdata[66:35] !== e.vel || out_tdata[98:67] !== e.acc ||
              out_tuser[0] !== e.status || out_tlast !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp j=%0d p=%h v=%h a=%h st=%b l=%b",
                        " got j=%0d p=%h v=%h a=%h st=%b l=%b"},
                       e.joint, e.pos, e.vel, e.acc, e.status, e.last,
                       out_tdata[2:0], out_tdata[34:3], out_tdata[66:35],
                       out_tdata[98:67], out_tuser[0], out_tlast);
          end
        end
      end
      out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
    end
  end

  function automatic seg_item_t make_load(logic [2:0] jn, logic [31:0] s, logic [31:0] e,
                                          logic [31:0] p0, logic [31:0] v0, logic [31:0] a0,
                                          logic [31:0] p1, logic [31:0] v1, logic [31:0] a1);
    seg_item_t it;
    it = '{kind: KIND_LOAD, joint: jn, seg_start: s, seg_end: e, p0: p0, v0: v0, a0: a0,
           p1: p1, v1: v1, a1: a1, qtime: $urandom};
    return it;
  endfunction

  function automatic seg_item_t make_query(logic [31:0] t);
    seg_item_t it;
    it = '{kind: KIND_QUERY, joint: 3'($urandom), seg_start: $urandom, seg_end: $urandom,
           p0: $urandom, v0: $urandom, a0: $urandom, p1: $urandom, v1: $urandom,
           a1: $urandom, qtime: t};
    return it;
  endfunction

  function automatic logic [31:0] rand_kin();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      2: return 32'($signed($urandom_range(0, 2 * 65536 * 200)) - 65536 * 200);
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    wait (pending_kin.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(make_query(32'h0100_0000));
    send_item(make_query(32'hFFFF_FFFF));
    send_item(make_load(3'd0, 32'd0, 32'h0100_0000, 32'h0001_0000, '0, '0,
                        32'h0005_0000, '0, '0));
    send_item(make_load(3'd1, 32'd100, 32'd101, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(make_load(3'd2, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(make_load(3'd3, 32'h0080_0000, 32'h0280_0000, 32'hFFFF_0000, 32'h0000_8000,
                        32'hFFFF_C000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_4000));
    send_item(make_load(3'd5, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0,
                        32'd1, 32'hFFFF_FFFF, 32'd0));
    send_item(make_load(3'd4, 32'h0300_0000, 32'h0300_0000, 32'h1234_5678, '0, '0, '0, '0, '0));
    send_item(make_load(3'd4, 32'h0300_0000, 32'h0200_0000, 32'h1234_5678, '0, '0, '0, '0, '0));
    send_item(make_load(3'd6, 32'd0, 32'h0100_0000, 32'h0001_0000, '0, '0, '0, '0, '0));
    send_item(make_load(3'd7, 32'd0, 32'h0100_0000, 32'h0001_0000, '0, '0, '0, '0, '0));
    send_item(make_query(32'd0));
    send_item(make_query(32'h0080_0000));
    send_item(make_query(32'h0100_0000));
    send_item(make_query(32'h0180_0000));
    send_item(make_query(32'h0280_0000));
    send_item(make_query(32'd100));
    send_item(make_query(32'hFFFF_FFFE));
    send_item(make_query(32'hFFFF_FFFF));
    send_item(make_query(32'h7FFF_FFFF));
  endtask

  task automatic test_random(int count);
    seg_item_t it;
    logic [31:0] s, tq, t;
    int jn;
    for (int n = 0; n < count; n++) begin
      calm = (n >= 150 && n < 250);
      if (n % 120 == 60) wait_drained();
      if ($urandom_range(99) < 40) begin
        case ($urandom_range(9))
          0, 1, 2: tq = $urandom_range(1, 255);
          3, 4, 5, 6: tq = $urandom_range(32'h0010_0000, 32'h0400_0000);
          7: tq = $urandom;
          default: tq = $urandom_range(256, 32'h000F_FFFF);
        endcase
        s = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h0800_0000);
        if ($urandom_range(19) == 0) tq = 0;
        jn = ($urandom_range(19) == 0) ? $urandom_range(6, 7) : $urandom_range(0, NJ - 1);
        it = make_load(3'(jn), s, s + tq, rand_kin(), rand_kin(), rand_kin(),
                       rand_kin(), rand_kin(), rand_kin());
      end else begin
        jn = $urandom_range(0, NJ - 1);
        case ($urandom_range(7))
          0: t = $urandom;
          1: t = seg_t0[jn];
          2: t = seg_t1[jn];
          3: t = seg_t0[jn] - $urandom_range(0, 1000);
          4: t = seg_t1[jn] + $urandom_range(0, 1000);
          default: t = seg_t0[jn] + $urandom_range(0, seg_t1[jn] - seg_t0[jn]);
        endcase
        it = make_query(t);
      end
      send_item(it);
    end
    calm = 0;
  endtask

  initial begin
    for (int i = 0; i < NJ*6; i++) coef_bank[i] = '0;
    for (int i = 0; i < NJ; i++) begin
      seg_t0[i] = '0;
      seg_t1[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(450);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && pending_kin.size() == 0) begin
      $display("quintic_segment_interpolator_core verification clean");
    end else begin
      $display("quintic_segment_interpolator_core verification failed");
    end
    $finish;
  end

endmodule
